### rtl/csfu_pkg.sv
// ----------------------------------------------------------------------------
// csfu_pkg
// Shared types for the counting semaphore unit: operation codes, controller
// states, the command and status bundles and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package csfu_pkg;

  localparam int PID_W   = 6;
  localparam int COUNT_W = 9;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_ACQ  = 2'd1,
    OP_REL  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [7:0] {
    ST_CLR   = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_CHECK = 8'b0000_0100,
    ST_ICLR  = 8'b0000_1000,
    ST_SCAN  = 8'b0001_0000,
    ST_WREM  = 8'b0010_0000,
    ST_WADD  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic take;
    logic sweep_all;
    logic sweep_sem;
    logic exec;
    logic scan;
    logic wrem;
    logic wadd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic sem_ok;
    op_t  op;
    logic acq_scan;
    logic scan_done;
    logic swp_all_last;
    logic swp_sem_last;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    logic                       not_holder;
    logic                       holders_full;
    logic                       queue_overflow;
    logic signed [COUNT_W-1:0]  new_count;
    logic [PID_W-1:0]           wake_proc;
    logic                       wake_valid;
    logic                       blocked;
    logic                       granted;
  } res_t;

endpackage

`default_nettype wire

### rtl/csfu_ram.sv
// ----------------------------------------------------------------------------
// csfu_ram
// Generic memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/csfu_datapath.sv
// ----------------------------------------------------------------------------
// csfu_datapath
// Counts, ring pointers, wait ring and holder table memories, holder scan
// and the result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module csfu_datapath
  import csfu_pkg::*;
#(
  parameter int NUM_SEMS     = 8,
  parameter int QUEUE_DEPTH  = 16,
  parameter int HOLDER_SLOTS = 16,
  parameter int PROC_ID_BITS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire logic [23:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata
);

  localparam int SW     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QW     = $clog2(QUEUE_DEPTH);
  localparam int HW     = (HOLDER_SLOTS > 1) ? $clog2(HOLDER_SLOTS) : 1;
  localparam int HCW    = $clog2(HOLDER_SLOTS + 1);
  localparam int HDEPTH = NUM_SEMS * HOLDER_SLOTS;
  localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int RDEPTH = NUM_SEMS * QUEUE_DEPTH;
  localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam logic [PID_W-1:0] PID_MASK =
    (PROC_ID_BITS >= PID_W) ? {PID_W{1'b1}} : PID_W'((1 << PROC_ID_BITS) - 1);
  localparam logic signed [COUNT_W-1:0] QMIN = 9'sd0 - 9'(QUEUE_DEPTH);
  localparam logic signed [COUNT_W-1:0] CMAX = 9'sd255;

  op_t              op_r;
  logic [2:0]       sem_r;
  logic [PID_W-1:0] pid_r;
  logic [7:0]       ival_r;

  logic signed [COUNT_W-1:0] count_r [NUM_SEMS];
  logic [QW-1:0]             head_r  [NUM_SEMS];
  logic [QW-1:0]             tail_r  [NUM_SEMS];

  logic [HCW-1:0]  iss_r;
  logic            pend_r;
  logic [HW-1:0]   pslot_r;
  logic            fz_r, fm_r;
  logic [HW-1:0]   zidx_r, midx_r;
  logic [HAW-1:0]  swp_r;
  res_t            res_r;
  res_t            res_nxt;
  logic            out_valid_r;
  res_t            out_r;

  logic [SW-1:0]             sidx;
  logic                      sem_ok;
  logic signed [COUNT_W-1:0] cnt, dec_c, rel_c;
  logic                      grant, ovf, wake;
  logic [HAW-1:0]            hbase;
  logic [RAW-1:0]            rbase;
  logic [PID_W-1:0]          h_rdata, r_rdata, add_pid;
  logic                      issue;
  logic                      use_m, need_add, free;
  logic [HW-1:0]             add_slot;
  logic                      h_we;
  logic [HAW-1:0]            h_waddr;
  logic [PID_W-1:0]          h_wdata;

  function automatic logic [QW-1:0] ring_inc(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign sidx   = SW'(sem_r);
  assign sem_ok = int'(sem_r) < NUM_SEMS;
  assign cnt    = count_r[sidx];
  assign dec_c  = cnt - 9'sd1;
  assign rel_c  = (cnt < CMAX) ? cnt + 9'sd1 : cnt;
  assign grant  = cnt > 9'sd0;
  assign ovf    = cnt <= QMIN;
  assign wake   = rel_c <= 9'sd0;
  assign hbase  = HAW'(int'(sidx) * HOLDER_SLOTS);
  assign rbase  = RAW'(int'(sidx) * QUEUE_DEPTH);
  assign issue  = cmd.scan && (iss_r != HCW'(HOLDER_SLOTS));

  // holder to record: the caller on acquire, the woken process on release
  always_comb begin
    use_m = fm_r && (!fz_r || (midx_r < zidx_r));
    if (op_r == OP_ACQ) begin
      add_pid  = pid_r;
      need_add = pid_r != '0;
      add_slot = zidx_r;
      free     = fz_r;
    end else begin
      add_pid  = r_rdata;
      need_add = res_r.wake_valid && (r_rdata != '0);
      add_slot = use_m ? midx_r : zidx_r;
      free     = fz_r || fm_r;
    end
  end

  always_comb begin
    h_we    = 1'b0;
    h_waddr = hbase;
    h_wdata = '0;
    priority if (cmd.sweep_all) begin
      h_we    = 1'b1;
      h_waddr = swp_r;
    end else if (cmd.sweep_sem) begin
      h_we    = 1'b1;
      h_waddr = hbase + swp_r;
    end else if (cmd.wrem) begin
      h_we    = fm_r;
      h_waddr = hbase + HAW'(midx_r);
    end else if (cmd.wadd) begin
      h_we    = need_add && free;
      h_waddr = hbase + HAW'(add_slot);
      h_wdata = add_pid;
    end
  end

  csfu_ram #(.WIDTH(PID_W), .DEPTH(HDEPTH)) u_holders (
    .clk     (clk),
    .wr_en   (h_we),
    .wr_addr (h_waddr),
    .wr_data (h_wdata),
    .rd_en   (issue),
    .rd_addr (hbase + HAW'(iss_r[HW-1:0])),
    .rd_data (h_rdata)
  );

  csfu_ram #(.WIDTH(PID_W), .DEPTH(RDEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (cmd.exec && sem_ok && (op_r == OP_ACQ) && !grant && !ovf),
    .wr_addr (rbase + RAW'(tail_r[sidx])),
    .wr_data (pid_r),
    .rd_en   (cmd.exec && (op_r == OP_REL)),
    .rd_addr (rbase + RAW'(head_r[sidx])),
    .rd_data (r_rdata)
  );

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= op_t'(in_tdata[1:0]);
      sem_r  <= in_tdata[4:2];
      pid_r  <= in_tdata[10:5] & PID_MASK;
      ival_r <= in_tdata[18:11];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        count_r[i] <= '0;
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
      end
    end else if (cmd.exec && sem_ok) begin
      unique case (op_r)
        OP_INIT: begin
          count_r[sidx] <= {1'b0, ival_r};
          head_r[sidx]  <= '0;
          tail_r[sidx]  <= '0;
        end
        OP_ACQ: begin
          if (grant) begin
            count_r[sidx] <= dec_c;
          end else if (!ovf) begin
            count_r[sidx] <= dec_c;
            tail_r[sidx]  <= ring_inc(tail_r[sidx]);
          end
        end
        OP_REL: begin
          count_r[sidx] <= rel_c;
          if (wake) begin
            head_r[sidx] <= ring_inc(head_r[sidx]);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_r <= '0;
    end else if (cmd.sweep_all || cmd.sweep_sem) begin
      swp_r <= (sts.swp_all_last || (cmd.sweep_sem && sts.swp_sem_last)) ? '0 : swp_r + 1'b1;
    end
  end

  // holder scan: issue one read a cycle, compare the read data in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r  <= '0;
      pend_r <= 1'b0;
      fz_r   <= 1'b0;
      fm_r   <= 1'b0;
    end else if (cmd.exec) begin
      iss_r  <= '0;
      pend_r <= 1'b0;
      fz_r   <= 1'b0;
      fm_r   <= 1'b0;
    end else begin
      pend_r <= issue;
      if (issue) begin
        iss_r   <= iss_r + 1'b1;
        pslot_r <= iss_r[HW-1:0];
      end
      if (pend_r) begin
        if (!fz_r && (h_rdata == '0)) begin
          fz_r   <= 1'b1;
          zidx_r <= pslot_r;
        end
        if (!fm_r && (pid_r != '0) && (h_rdata == pid_r)) begin
          fm_r   <= 1'b1;
          midx_r <= pslot_r;
        end
      end
    end
  end

  always_comb begin
    res_nxt = res_r;
    if (cmd.exec) begin
      res_nxt = '0;
      if (sem_ok) begin
        unique case (op_r)
          OP_INIT: res_nxt.new_count = {1'b0, ival_r};
          OP_ACQ: begin
            if (grant) begin
              res_nxt.granted   = 1'b1;
              res_nxt.new_count = dec_c;
            end else if (ovf) begin
              res_nxt.queue_overflow = 1'b1;
              res_nxt.new_count      = cnt;
            end else begin
              res_nxt.blocked   = 1'b1;
              res_nxt.new_count = dec_c;
            end
          end
          OP_REL: begin
            res_nxt.new_count  = rel_c;
            res_nxt.wake_valid = wake;
          end
          default: res_nxt.new_count = cnt;
        endcase
      end
    end else if (cmd.wrem) begin
      res_nxt.not_holder = !fm_r;
      if (res_r.wake_valid) begin
        res_nxt.wake_proc = r_rdata;
      end
    end else if (cmd.wadd) begin
      res_nxt.holders_full = need_add && !free;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r};

  always_comb begin
    sts.sem_ok       = sem_ok;
    sts.op           = op_r;
    sts.acq_scan     = grant && (pid_r != '0);
    sts.scan_done    = (iss_r == HCW'(HOLDER_SLOTS)) && !pend_r;
    sts.swp_all_last = swp_r == HAW'(HDEPTH - 1);
    sts.swp_sem_last = swp_r == HAW'(HOLDER_SLOTS - 1);
    sts.out_busy     = out_valid_r && !out_tready;
  end

endmodule

`default_nettype wire

### rtl/csfu_ctrl.sv
// ----------------------------------------------------------------------------
// csfu_ctrl
// Sequencer: reset clear, item intake, holder scan, table writes and result
// hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module csfu_ctrl
  import csfu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLR: begin
        cmd.sweep_all = 1'b1;
        if (sts.swp_all_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.take  = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.exec = 1'b1;
        priority if (!sts.sem_ok || sts.op == OP_NONE) begin
          state_nxt = ST_DONE;
        end else if (sts.op == OP_INIT) begin
          state_nxt = ST_ICLR;
        end else if (sts.op == OP_REL || sts.acq_scan) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_ICLR: begin
        cmd.sweep_sem = 1'b1;
        if (sts.swp_sem_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = (sts.op == OP_REL) ? ST_WREM : ST_WADD;
        end
      end
      ST_WREM: begin
        cmd.wrem  = 1'b1;
        state_nxt = ST_WADD;
      end
      ST_WADD: begin
        cmd.wadd  = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

`ifndef SYNTHESIS
  a_take_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r == ST_CHECK)
    else $error("accepted word did not move to check");

  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && sts.scan_done) |=> (state_r == ST_WREM || state_r == ST_WADD))
    else $error("scan did not lead to a holder write");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("result loaded over a waiting word");
`endif

endmodule

`default_nettype wire

### rtl/counting_semaphore_fifo_unit_core.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_unit_core
// Bank of counting semaphores with FIFO wait rings and holder tables.
// ----------------------------------------------------------------------------
// One word in gives one result word out. Init clears the holder slots of its
// semaphore, one holder slot cleared per cycle. For a valid semaphore, an acquire
// granted to a nonzero process and any release go through the one-slot-per-cycle
// scan of the holder table memory; other words skip the holder table. After reset
// the whole holder memory of NUM_SEMS * HOLDER_SLOTS entries is cleared, during
// which in_tready stays low. A finished result waits in the output register
// while the next word is taken.
`default_nettype none

module counting_semaphore_fifo_unit_core
  import csfu_pkg::*;
#(
  parameter int NUM_SEMS     = 8,
  parameter int QUEUE_DEPTH  = 16,
  parameter int HOLDER_SLOTS = 16,
  parameter int PROC_ID_BITS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] operation, [4:2] sem_id, [10:5] proc_id, [18:11] init_value
  input  wire logic [23:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] granted, [1] blocked, [2] wake_valid, [8:3] wake_proc,
  // [17:9] new_count, [18] queue_overflow, [19] holders_full, [20] not_holder
  output logic [23:0]      out_tdata
);

  cmd_t cmd;
  sts_t sts;

  csfu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csfu_datapath #(
    .NUM_SEMS     (NUM_SEMS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .HOLDER_SLOTS (HOLDER_SLOTS),
    .PROC_ID_BITS (PROC_ID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
